>>> hdl/nat_pkg.sv
// Shared types, command codes and field widths for the neighbor address table.
package nat_pkg;

    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 8;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;
    localparam int TYPE_LO = 32;
    localparam int TYPE_HI = 39;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_ADD    = 3'd0;
    localparam t_cmd CMD_LOOKUP = 3'd1;
    localparam t_cmd CMD_NEXT   = 3'd2;
    localparam t_cmd CMD_COUNT  = 3'd3;
    localparam t_cmd CMD_READ   = 3'd4;
    localparam t_cmd CMD_CLEAR  = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic cmp;
        logic finish;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic scan_end;
    } t_dp_sts;

endpackage

>>> hdl/nat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nat_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/nat_ctrl.sv
// Request sequencer for the neighbor address table.
module nat_ctrl
    import nat_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl,
    output logic    o_busy,
    output logic    o_done
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_done, n_done;

    always_comb begin
        n_state      = r_state;
        n_done       = 1'b0;
        o_ctl        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_ctl.step = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_ctl.step = 1'b1;
                o_ctl.cmp  = 1'b1;
                if (i_sts.scan_end) begin
                    o_ctl.finish = 1'b1;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

>>> hdl/nat_dpath.sv
// Table storage, scan pointers, comparators and result registers.
module nat_dpath
    import nat_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_ctl            i_ctl,
    output t_dp_sts            o_sts,
    input  t_cmd               i_cmd,
    input  logic [ADDR_W-1:0]  i_mac_address,
    input  logic [BYTE_W-1:0]  i_node_type,
    input  logic [IDX_W-1:0]   i_start_index,
    input  logic [IDX_W-1:0]   i_entry_index,
    output logic               o_hit,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [COUNT_W-1:0] o_type_count,
    output logic [ADDR_W-1:0]  o_address_out
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW = $clog2(TABLE_DEPTH + 1);

    t_cmd               r_cmd;
    logic [ADDR_W-1:0]  r_key;
    logic [BYTE_W-1:0]  r_type;
    logic [IDX_W-1:0]   r_ptr;
    logic [IDX_W-1:0]   r_cur;
    logic [IDX_W-1:0]   r_cnt;
    logic [FW-1:0]      r_fill;
    logic               r_hit;
    logic [SLOT_W-1:0]  r_slot;
    logic [COUNT_W-1:0] r_count;
    logic [ADDR_W-1:0]  r_aout;

    logic [ADDR_W-1:0]  w_q;
    logic               w_in_table;
    logic               w_addr_match;
    logic               w_type_match;
    logic               w_full;
    logic               w_in_range;
    logic               w_we;
    logic [IDX_W-1:0]   w_first;

    logic               n_hit;
    logic [SLOT_W-1:0]  n_slot;
    logic [COUNT_W-1:0] n_count;
    logic [ADDR_W-1:0]  n_aout;

    // valid entries always form a prefix, so the fill count stands in for valid bits
    assign w_in_table   = (r_cur < IDX_W'(r_fill));
    assign w_addr_match = w_in_table && (w_q == r_key);
    assign w_type_match = w_in_table && (w_q[TYPE_HI:TYPE_LO] == r_type);
    assign w_full       = (r_fill == FW'(TABLE_DEPTH));
    assign w_in_range   = ({1'b0, r_cur} < (IDX_W + 1)'(TABLE_DEPTH));

    always_comb begin
        case (i_cmd)
            CMD_NEXT: w_first = i_start_index;
            CMD_READ: w_first = i_entry_index;
            default:  w_first = '0;
        endcase
    end

    always_comb begin
        o_sts.scan_end = 1'b1;
        n_hit          = 1'b0;
        n_slot         = '0;
        n_count        = '0;
        n_aout         = '0;
        unique case (r_cmd)
            CMD_ADD: begin
                o_sts.scan_end = w_addr_match || !w_in_table;
                if (w_addr_match) begin
                    n_hit  = 1'b1;
                    n_slot = r_cur[SLOT_W-1:0];
                end else if (!w_full) begin
                    n_hit  = 1'b1;
                    n_slot = SLOT_W'(r_fill);
                end
            end
            CMD_LOOKUP: begin
                o_sts.scan_end = w_addr_match || !w_in_table;
                n_hit          = w_addr_match;
                n_slot         = w_addr_match ? r_cur[SLOT_W-1:0] : '0;
            end
            CMD_NEXT: begin
                o_sts.scan_end = w_type_match || !w_in_table;
                n_hit          = w_type_match;
                n_slot         = w_type_match ? r_cur[SLOT_W-1:0] : '0;
            end
            CMD_COUNT: begin
                o_sts.scan_end = !w_in_table;
                n_count        = r_cnt[COUNT_W-1:0];
            end
            CMD_READ: begin
                n_hit  = w_in_range;
                n_slot = w_in_range ? r_cur[SLOT_W-1:0] : '0;
                n_aout = w_in_table ? w_q : '0;
            end
            default: begin
                o_sts.scan_end = 1'b1;
            end
        endcase
    end

    assign w_we = i_ctl.finish && (r_cmd == CMD_ADD) && !w_addr_match && !w_full;

    nat_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(AW)
    ) u_addr_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_fill[AW-1:0]),
        .i_wdata(r_key),
        .i_raddr(r_ptr[AW-1:0]),
        .o_rdata(w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctl.finish) begin
            if (r_cmd == CMD_CLEAR) begin
                r_fill <= '0;
            end else if (w_we) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_key  <= i_mac_address;
            r_type <= i_node_type;
            r_ptr  <= w_first;
            r_cnt  <= '0;
        end else if (i_ctl.step) begin
            r_cur <= r_ptr;
            r_ptr <= r_ptr + 1'b1;
            if (i_ctl.cmp && w_type_match) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (i_ctl.finish) begin
            r_hit   <= n_hit;
            r_slot  <= n_slot;
            r_count <= n_count;
            r_aout  <= n_aout;
        end
    end

    assign o_hit         = r_hit;
    assign o_slot        = r_slot;
    assign o_type_count  = r_count;
    assign o_address_out = r_aout;

endmodule

>>> hdl/neighbor_address_table_unit.sv
// Sequence: the accepting edge loads the request, an issue state primes the RAM read, and the scan
// state passes over slots until it stops on a match (not for count), an empty slot or the end.
// Throughput: one request at a time; busy holds until the result is registered, one slot per cycle
// through the registered read port of the address RAM.
// Read entry, clear and unused codes finish in the first scan state without passing over slots.
// Reset empties the table (fill count to zero); the receiver cannot stall.
module neighbor_address_table_unit
    import nat_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_cmd               i_cmd,
    input  logic [ADDR_W-1:0]  i_mac_address,
    input  logic [BYTE_W-1:0]  i_link_quality,
    input  logic [BYTE_W-1:0]  i_signal_strength,
    input  logic [BYTE_W-1:0]  i_node_type,
    input  logic [IDX_W-1:0]   i_start_index,
    input  logic [IDX_W-1:0]   i_entry_index,
    output logic               o_done,
    output logic               o_hit,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [COUNT_W-1:0] o_type_count,
    output logic [ADDR_W-1:0]  o_address_out
);

    t_dp_ctl w_ctl;
    t_dp_sts w_sts;

    nat_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (w_sts),
        .o_ctl  (w_ctl),
        .o_busy (busy),
        .o_done (o_done)
    );

    // quality and strength are accepted with each request but never reported
    nat_dpath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_sts        (w_sts),
        .i_cmd        (i_cmd),
        .i_mac_address(i_mac_address),
        .i_node_type  (i_node_type),
        .i_start_index(i_start_index),
        .i_entry_index(i_entry_index),
        .o_hit        (o_hit),
        .o_slot       (o_slot),
        .o_type_count (o_type_count),
        .o_address_out(o_address_out)
    );

endmodule
